### rtl/ias_pkg.sv
// Shared types for the integer array sorter.
// No dependencies; imported by the cell and the top level.
package ias_pkg;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;    // insert the arriving value into the sorted chain
    logic shift;  // move every cell one place towards the output end
  } cell_ctrl_t;

endpackage

### rtl/ias_cell.sv
// One cell of the systolic insertion chain: holds one value and its valid bit.
// Depends on ias_pkg for the command struct.
module ias_cell import ias_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cell_ctrl_t                    ctrl_i,
  input  logic signed [VALUE_WIDTH-1:0] ins_value_i,
  input  logic signed [VALUE_WIDTH-1:0] left_value_i,
  input  logic                          left_valid_i,
  input  logic                          left_lt_i,
  input  logic signed [VALUE_WIDTH-1:0] right_value_i,
  input  logic                          right_valid_i,
  output logic signed [VALUE_WIDTH-1:0] value_o,
  output logic                          valid_o,
  output logic                          lt_o
);

  logic signed [VALUE_WIDTH-1:0] value_q, value_d;
  logic                          valid_q, valid_d;

  // New value goes ahead of this cell when the cell is empty or holds more.
  assign lt_o = !valid_q || (ins_value_i < value_q);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      value_d = right_value_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.ins && lt_o) begin
      if (left_lt_i) begin
        // take the left neighbour, which is pushed along by the insert
        value_d = left_value_i;
        valid_d = left_valid_i;
      end else begin
        value_d = ins_value_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

### rtl/integer_array_sorter.sv
// Integer array sorter: a chain of MAX_COUNT insertion cells kept in ascending order.
// Load: one item per cycle while busy is low, each placed in its sorted position in the
// cycle it arrives (dropped once the chain is full). Unload: after the item marked last,
// busy rises and the chain shifts one result out per cycle until the final one has left.
// The receiver cannot stall; results stream in consecutive cycles with res_valid_o.
// Reset (asynchronous, active low) empties the chain, clears the count and overflow.
module integer_array_sorter import ias_pkg::*; #(
  parameter int MAX_COUNT   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic                          last_i,
  output logic                          res_valid_o,
  output logic signed [VALUE_WIDTH-1:0] value_res_o,
  output logic                          last_res_o,
  output logic                          overflow_o
);

  localparam int CntW = $clog2(MAX_COUNT + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            dropped_q, dropped_d;
  logic            accept;
  logic            full;
  cell_ctrl_t      ctrl;

  // Chain taps: one entry per cell, plus an empty slot past the far end.
  logic signed [VALUE_WIDTH-1:0] cell_value [MAX_COUNT+1];
  logic                          cell_valid [MAX_COUNT+1];
  logic                          cell_lt    [MAX_COUNT];

  assign accept = start && !busy_q;
  assign full   = (cnt_q == CntW'(MAX_COUNT));

  // Insert only while room is left; a full chain drops the item.
  assign ctrl.ins   = accept && !full;
  assign ctrl.shift = busy_q;

  // The slot past the last cell feeds empties into the chain while unloading.
  assign cell_value[MAX_COUNT] = '0;
  assign cell_valid[MAX_COUNT] = 1'b0;

  for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] left_value;
    logic                          left_valid;
    logic                          left_lt;

    if (i == 0) begin : g_head
      // nothing to the left of the head cell, so it never takes a neighbour
      assign left_value = '0;
      assign left_valid = 1'b0;
      assign left_lt    = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_lt    = cell_lt[i-1];
    end

    ias_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .ins_value_i   (value_i),
      .left_value_i  (left_value),
      .left_valid_i  (left_valid),
      .left_lt_i     (left_lt),
      .right_value_i (cell_value[i+1]),
      .right_valid_i (cell_valid[i+1]),
      .value_o       (cell_value[i]),
      .valid_o       (cell_valid[i]),
      .lt_o          (cell_lt[i])
    );
  end

  always_comb begin
    cnt_d     = cnt_q;
    busy_d    = busy_q;
    dropped_d = dropped_q;
    if (accept) begin
      // count stored items; remember any drop for the whole set
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
      if (last_i) begin
        busy_d = 1'b1;
        cnt_d  = '0;
      end
    end
    if (busy_q && last_res_o) begin
      // final item leaves: release the chain for the next set
      busy_d    = 1'b0;
      dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      busy_q    <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      busy_q    <= busy_d;
      dropped_q <= dropped_d;
    end
  end

  // Head cell holds the smallest remaining item; the run ends when the next cell is empty.
  assign busy        = busy_q;
  assign res_valid_o = busy_q;
  assign value_res_o = cell_value[0];
  assign last_res_o  = busy_q && !cell_valid[1];
  assign overflow_o  = busy_q && dropped_q;

endmodule

### rtl/ias_checker.sv
// Port-level checker for the integer array sorter, bound to the top level.
// Depends only on the top level's ports.
module ias_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          last_i,
  input logic                          res_valid_o,
  input logic signed [VALUE_WIDTH-1:0] value_res_o,
  input logic                          last_res_o,
  input logic                          overflow_o
);

  // A last item always opens an unload run.
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && last_i |=> busy)
    else $error("last item did not start unload");

  // Results stream without gaps while busy.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> res_valid_o)
    else $error("gap in result stream");

  // The final result ends the run.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && last_res_o |=> !busy)
    else $error("busy held after final result");

  // Results leave in ascending order with a constant overflow flag.
  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_res_o |=>
      res_valid_o && ($past(value_res_o) <= value_res_o) && $stable(overflow_o))
    else $error("results out of order or overflow changed");

endmodule

bind integer_array_sorter ias_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_ias_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .last_i      (last_i),
  .res_valid_o (res_valid_o),
  .value_res_o (value_res_o),
  .last_res_o  (last_res_o),
  .overflow_o  (overflow_o)
);

### verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for integer_array_sorter: streams sets of signed values, each ended
// by a last mark, and checks every sorted result against an in-bench model of the sort.
// Depends only on the RTL of integer_array_sorter and its package.
module tb_top;

  localparam int MAX_COUNT   = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int ITEM_TARGET = 250;

  // Extreme values of the element field.
  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  // One expected output item of the sorted run.
  typedef struct {
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last;
    logic                          overflow;
  } sorted_result_t;

  // Gathers the elements of the open set, and once the last mark arrives queues the
  // whole set in ascending order. Output items are checked against the oldest entry.
  class sorted_run_tracker;
    logic signed [VALUE_WIDTH-1:0] held[$];
    bit                            dropped;
    sorted_result_t                expected_sorted[$];
    int unsigned                   mismatches;
    int unsigned                   results_checked;
    int unsigned                   sets_sorted;
    int unsigned                   overflow_sets;

    function void note_element(logic signed [VALUE_WIDTH-1:0] v, logic l);
      logic signed [VALUE_WIDTH-1:0] cur;
      int                            j;
      sorted_result_t                r;
      if (held.size() < MAX_COUNT) held = {held, v};
      else dropped = 1'b1;
      if (l !== 1'b1) return;
      // Insertion sort, signed ascending; equal values need no stable order.
      for (int i = 1; i < held.size(); i++) begin
        cur = held[i];
        j = i;
        while (j > 0 && held[j-1] > cur) begin
          held[j] = held[j-1];
          j--;
        end
        held[j] = cur;
      end
      for (int k = 0; k < held.size(); k++) begin
        r.value    = held[k];
        r.last     = (k == held.size() - 1);
        r.overflow = dropped;
        expected_sorted = {expected_sorted, r};
      end
      sets_sorted++;
      if (dropped) overflow_sets++;
      held.delete();
      dropped = 1'b0;
    endfunction

    function void report(string what, sorted_result_t want, sorted_result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected value %0d last %b ovf %b, got value %0d last %b ovf %b",
                 $time, what, want.value, want.last, want.overflow,
                 got.value, got.last, got.overflow);
    endfunction

    function void check_output(logic signed [VALUE_WIDTH-1:0] v, logic l, logic o);
      sorted_result_t want;
      sorted_result_t got;
      got.value    = v;
      got.last     = l;
      got.overflow = o;
      results_checked++;
      if (expected_sorted.size() == 0) begin
        want = '{default: 'x};
        report("unexpected item", want, got);
        return;
      end
      want = expected_sorted.pop_front();
      if (got.value !== want.value || got.last !== want.last || got.overflow !== want.overflow)
        report("wrong item", want, got);
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic signed [VALUE_WIDTH-1:0] value_i = '0;
  logic                          last_i = 1'b0;
  logic                          res_valid_o;
  logic signed [VALUE_WIDTH-1:0] value_res_o;
  logic                          last_res_o;
  logic                          overflow_o;

  sorted_run_tracker tracker;
  int unsigned       items_sent;
  int unsigned       idle_pct;

  integer_array_sorter #(
    .MAX_COUNT  (MAX_COUNT),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .value_i    (value_i),
    .last_i     (last_i),
    .res_valid_o(res_valid_o),
    .value_res_o(value_res_o),
    .last_res_o (last_res_o),
    .overflow_o (overflow_o)
  );

  // 20 ns clock: high half, then low half.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Observe the handshakes at the edge. The bench and the block both update with
  // nonblocking assignments, so the values read here are those from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) tracker.check_output(value_res_o, last_res_o, overflow_o);
      if (start && !busy) tracker.note_element(value_i, last_i);
    end
  end

  // Pick an element: mostly full-width random, with extremes and a narrow band around
  // zero so that duplicates and sign changes turn up often.
  function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(9))
      0:       return VALUE_MIN;
      1:       return VALUE_MAX;
      2, 3:    return $signed($urandom_range(15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Present one item and hold it until the block takes it. Called in the time step of a
  // rising edge; returns in the time step of the edge that accepted the item.
  task automatic send_element(logic signed [VALUE_WIDTH-1:0] v, logic l);
    if ($urandom_range(99) < idle_pct) begin
      // Drop start for a short gap so idle cycles land on every phase of the work.
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start   <= 1'b1;
    value_i <= v;
    last_i  <= l;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  // Send a whole set of random elements, the last one marked.
  task automatic send_set(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_element(pick_value(), i == len - 1);
  endtask

  // Stop a hung run; the limit is generous against the slowest legal run.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned roll;
    int unsigned len;
    tracker    = new;
    items_sent = 0;
    idle_pct   = 31;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: single-element sets at both extremes.
    send_element(VALUE_MIN, 1'b1);
    send_element(VALUE_MAX, 1'b1);
    // Extremes and the values around zero in one set, largest first.
    send_element(VALUE_MAX, 1'b0);
    send_element(VALUE_MIN, 1'b0);
    send_element(0, 1'b0);
    send_element(-1, 1'b0);
    send_element(1, 1'b1);
    // Overfill the store: two elements beyond capacity, the second dropped one carrying the
    // last mark, which must still release the stored elements with overflow set.
    for (int i = 0; i < MAX_COUNT + 2; i++)
      send_element($signed((i % 5) * 1000) - 2000 - i, i == MAX_COUNT + 1);

    // Random part: well-formed sets of random length and content. Sender gaps at 31 in
    // a hundred first, then 60, then none.
    while (items_sent < ITEM_TARGET) begin
      if (items_sent > 2 * ITEM_TARGET / 3) idle_pct = 0;
      else if (items_sent > ITEM_TARGET / 3) idle_pct = 60;
      roll = $urandom_range(99);
      if (roll < 10)      len = MAX_COUNT;
      else if (roll < 22) len = $urandom_range(MAX_COUNT + 1, MAX_COUNT + 4);
      else if (roll < 40) len = $urandom_range(1, 3);
      else                len = $urandom_range(1, MAX_COUNT - 1);
      send_set(len);
    end
    start <= 1'b0;

    // Drain: wait for every queued result, then leave room for any stray output.
    while (tracker.expected_sorted.size() != 0) @(posedge clk_i);
    repeat (MAX_COUNT + 4) @(posedge clk_i);

    $display("Run covered %0d elements in %0d sets (%0d with dropped elements).",
             items_sent, tracker.sets_sorted, tracker.overflow_sets);
    $display("Checked %0d sorted outputs, %0d wrong or unexpected, %0d never seen.",
             tracker.results_checked, tracker.mismatches, tracker.expected_sorted.size());
    if (tracker.mismatches == 0 && tracker.expected_sorted.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### integer_array_sorter.f
rtl/ias_pkg.sv
rtl/ias_cell.sv
rtl/integer_array_sorter.sv
rtl/ias_checker.sv
verif/tb_top.sv
